[sv/ldg_pkg.sv]
// Shared constants and types for the LED pixel dimming and gamma pipeline.
package ldg_pkg;

   localparam logic       MODE_PIXEL = 1'b0;
   localparam logic       MODE_WRITE = 1'b1;

   localparam logic [2:0] SEL_GAMMA_RED   = 3'd0;
   localparam logic [2:0] SEL_GAMMA_GREEN = 3'd1;
   localparam logic [2:0] SEL_GAMMA_BLUE  = 3'd2;
   localparam logic [2:0] SEL_DIM_LEVEL   = 3'd3;
   localparam logic [2:0] SEL_DIM_AMOUNT  = 3'd4;
   localparam logic [2:0] SEL_CORR_RED    = 3'd5;
   localparam logic [2:0] SEL_CORR_GREEN  = 3'd6;
   localparam logic [2:0] SEL_CORR_BLUE   = 3'd7;

   localparam logic [7:0] FULL_SCALE     = 8'hFF;
   localparam logic [4:0] LEVEL_MAX      = 5'd31;
   localparam logic [7:0] RESET_GLOBAL   = 8'hFF;

   // Request state leaving the front end, two stages after acceptance.
   typedef struct packed {
      logic       valid;
      logic       write;
      logic [2:0] sel;
      logic [7:0] idx;
      logic [7:0] data;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
      logic       on;
      logic [4:0] level;
      logic [7:0] dim;
   } front_type;

   // What one color lane needs from the front end.
   typedef struct packed {
      logic       corr_we;
      logic       gamma_we;
      logic [7:0] idx;
      logic [7:0] data;
      logic [7:0] x;
      logic [7:0] dim;
      logic [4:0] level;
   } lane_in_type;

endpackage

[sv/ldg_front.sv]
// Front end: brightness product, divide by full scale, dim level and dim amount tables.
module ldg_front import ldg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic       accept,
   input  logic [7:0] global_brightness,
   input  logic       mode,
   input  logic [7:0] red,
   input  logic [7:0] green,
   input  logic [7:0] blue,
   input  logic [7:0] led_brightness,
   input  logic       last_in,
   input  logic [2:0] table_select,
   input  logic [7:0] table_index,
   input  logic [7:0] table_data,
   output front_type  front
);

   logic        v1_ff, wr1_ff, last1_ff, on1_ff;
   logic [2:0]  sel1_ff;
   logic [7:0]  idx1_ff, data1_ff, r1_ff, g1_ff, b1_ff;
   logic [15:0] prod1_ff;

   logic        v2_ff, wr2_ff, last2_ff, on2_ff;
   logic [2:0]  sel2_ff;
   logic [7:0]  idx2_ff, data2_ff, r2_ff, g2_ff, b2_ff;
   logic [4:0]  level2_ff;
   logic [7:0]  dim2_ff;

   logic [4:0]  level_mem [256];
   logic [7:0]  dim_mem [256];

   logic [15:0] quot_sum;
   logic [7:0]  quot;
   logic [7:0]  lvl_addr;
   logic [4:0]  level_wdata;

   // Exact floor(x / 255) for any product of two bytes.
   assign quot_sum    = prod1_ff + {8'd0, prod1_ff[15:8]} + 16'd1;
   assign quot        = quot_sum[15:8];
   assign lvl_addr    = (quot == 8'd0) ? 8'd1 : quot;
   assign level_wdata = (data1_ff > {3'd0, LEVEL_MAX}) ? LEVEL_MAX : data1_ff[4:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wr1_ff   <= (mode == MODE_WRITE);
         sel1_ff  <= table_select;
         idx1_ff  <= table_index;
         data1_ff <= table_data;
         r1_ff    <= red;
         g1_ff    <= green;
         b1_ff    <= blue;
         last1_ff <= last_in;
         on1_ff   <= (global_brightness != 8'd0) && (led_brightness != 8'd0);
         prod1_ff <= {8'd0, global_brightness} * {8'd0, led_brightness};

         wr2_ff   <= wr1_ff;
         sel2_ff  <= sel1_ff;
         idx2_ff  <= idx1_ff;
         data2_ff <= data1_ff;
         r2_ff    <= r1_ff;
         g2_ff    <= g1_ff;
         b2_ff    <= b1_ff;
         last2_ff <= last1_ff;
         on2_ff   <= on1_ff;
      end
   end

   // Both tables are written by the request that sits at the stage where they are read,
   // so every pixel sees exactly the writes that were accepted ahead of it.
   always_ff @(posedge clock) begin
      if (en) begin
         if (v1_ff && wr1_ff && (sel1_ff == SEL_DIM_LEVEL)) begin
            level_mem[idx1_ff] <= level_wdata;
         end
         if (v1_ff && wr1_ff && (sel1_ff == SEL_DIM_AMOUNT)) begin
            dim_mem[idx1_ff] <= data1_ff;
         end
         level2_ff <= level_mem[lvl_addr];
         dim2_ff   <= dim_mem[lvl_addr];
      end
   end

   assign front = '{valid: v2_ff, write: wr2_ff, sel: sel2_ff, idx: idx2_ff,
                    data: data2_ff, red: r2_ff, green: g2_ff, blue: b2_ff,
                    last: last2_ff, on: on2_ff, level: level2_ff, dim: dim2_ff};

endmodule

[sv/ldg_lane.sv]
// One color lane: correction table, video scaling, channel scaling and gamma table.
module ldg_lane import ldg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  lane_in_type lane_in,
   output logic [7:0]  lane_out
);

   logic [7:0]  corr_mem [32];
   logic [7:0]  gamma_mem [256];

   logic [7:0]  corr3_ff, x3_ff, dim3_ff, idx3_ff, data3_ff;
   logic        gwe3_ff, gwe4_ff, gwe5_ff;
   logic [7:0]  vid4_ff, x4_ff, idx4_ff, data4_ff;
   logic [7:0]  gaddr5_ff, idx5_ff, data5_ff;
   logic [7:0]  gamma6_ff;

   logic [15:0] vid_prod;
   logic [7:0]  vid_in;
   logic [16:0] ch_prod;

   assign vid_prod = {8'd0, corr3_ff} * {8'd0, dim3_ff};
   assign vid_in   = vid_prod[15:8] +
                     {7'd0, (corr3_ff != 8'd0) && (dim3_ff != 8'd0)};
   assign ch_prod  = {9'd0, x4_ff} * {8'd0, {1'b0, vid4_ff} + 9'd1};

   always_ff @(posedge clock) begin
      if (reset) begin
         gwe3_ff <= 1'b0;
         gwe4_ff <= 1'b0;
         gwe5_ff <= 1'b0;
      end else if (en) begin
         gwe3_ff <= lane_in.gamma_we;
         gwe4_ff <= gwe3_ff;
         gwe5_ff <= gwe4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x3_ff     <= lane_in.x;
         dim3_ff   <= lane_in.dim;
         idx3_ff   <= lane_in.idx;
         data3_ff  <= lane_in.data;
         vid4_ff   <= vid_in;
         x4_ff     <= x3_ff;
         idx4_ff   <= idx3_ff;
         data4_ff  <= data3_ff;
         gaddr5_ff <= ch_prod[15:8];
         idx5_ff   <= idx4_ff;
         data5_ff  <= data4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (lane_in.corr_we) begin
            corr_mem[lane_in.idx[4:0]] <= lane_in.data;
         end
         corr3_ff <= corr_mem[lane_in.level];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (gwe5_ff) begin
            gamma_mem[idx5_ff] <= data5_ff;
         end
         gamma6_ff <= gamma_mem[gaddr5_ff];
      end
   end

   assign lane_out = gamma6_ff;

endmodule

[sv/led_pixel_dim_gamma_pipeline.sv]
// Top level of the LED pixel dimming and gamma pipeline: front end, three lanes, merge, skid.
//
//   channel  direction  ports                       handshake
//   req      in         req_mode .. req_table_data  req_valid / req_stall
//   rsp      out        rsp_out_red .. rsp_last_out rsp_valid / rsp_stall
//   csr      in         csr_write_data              csr_write_enable
//
// One request is taken every clock cycle while req_stall is low; each lookup table has one
// write and one read port and is read once per request, at one fixed stage, which sets
// that figure. Pixel results pass the front end, lanes and output register to rsp_valid.
// Table-write requests produce no result.
// Synchronous active-high reset clears the pipeline and sets global brightness to 255;
// the tables hold nothing defined until they are written.
// A stalled result parks in the output register and the next one in a skid register;
// only when the skid register is full does req_stall rise, for as long as it stays full.
module led_pixel_dim_gamma_pipeline import ldg_pkg::*; (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_mode,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   input  logic [7:0] req_led_brightness,
   input  logic       req_last_in,
   input  logic [2:0] req_table_select,
   input  logic [7:0] req_table_index,
   input  logic [7:0] req_table_data,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_red,
   output logic [7:0] rsp_out_green,
   output logic [7:0] rsp_out_blue,
   output logic [4:0] rsp_out_level5,
   output logic       rsp_last_out,

   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   // Fields that ride beside the lanes until the merge stage.
   typedef struct packed {
      logic       on;
      logic       last;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [4:0] level;
   } side_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [4:0] level;
      logic       last;
   } result_type;

   logic [7:0]  global_ff;
   logic        en;
   logic        accept;
   front_type   front;
   lane_in_type lane_red_in, lane_green_in, lane_blue_in;
   logic [7:0]  lane_red_out, lane_green_out, lane_blue_out;
   logic        corr_ok, front_wr;

   logic        pix_ff [4];
   side_type    side_ff [4];

   logic        push, pop;
   result_type  push_data;
   logic        out_valid_ff, skid_valid_ff;
   result_type  out_ff, skid_ff;

   // The whole pipeline moves together; it halts only while the skid register is full.
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         global_ff <= RESET_GLOBAL;
      end else if (csr_write_enable) begin
         global_ff <= csr_write_data;
      end
   end

   ldg_front u_front (
      .clock             (clock),
      .reset             (reset),
      .en                (en),
      .accept            (accept),
      .global_brightness (global_ff),
      .mode              (req_mode),
      .red               (req_red),
      .green             (req_green),
      .blue              (req_blue),
      .led_brightness    (req_led_brightness),
      .last_in           (req_last_in),
      .table_select      (req_table_select),
      .table_index       (req_table_index),
      .table_data        (req_table_data),
      .front             (front)
   );

   // Correction tables hold only 32 entries; writes beyond them are dropped.
   assign front_wr = front.valid && front.write;
   assign corr_ok  = (front.idx[7:5] == 3'd0);

   assign lane_red_in = '{corr_we: front_wr && corr_ok && (front.sel == SEL_CORR_RED),
                          gamma_we: front_wr && (front.sel == SEL_GAMMA_RED),
                          idx: front.idx, data: front.data, x: front.red,
                          dim: front.dim, level: front.level};
   assign lane_green_in = '{corr_we: front_wr && corr_ok && (front.sel == SEL_CORR_GREEN),
                            gamma_we: front_wr && (front.sel == SEL_GAMMA_GREEN),
                            idx: front.idx, data: front.data, x: front.green,
                            dim: front.dim, level: front.level};
   assign lane_blue_in = '{corr_we: front_wr && corr_ok && (front.sel == SEL_CORR_BLUE),
                           gamma_we: front_wr && (front.sel == SEL_GAMMA_BLUE),
                           idx: front.idx, data: front.data, x: front.blue,
                           dim: front.dim, level: front.level};

   ldg_lane u_lane_red (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .lane_in  (lane_red_in),
      .lane_out (lane_red_out)
   );

   ldg_lane u_lane_green (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .lane_in  (lane_green_in),
      .lane_out (lane_green_out)
   );

   ldg_lane u_lane_blue (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .lane_in  (lane_blue_in),
      .lane_out (lane_blue_out)
   );

   // Side pipeline, four stages deep to line up with the lane outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            pix_ff[i] <= 1'b0;
         end
      end else if (en) begin
         pix_ff[0] <= front.valid && (front.write == MODE_PIXEL);
         for (int i = 1; i < 4; i++) begin
            pix_ff[i] <= pix_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= '{on: front.on, last: front.last, red: front.red,
                         green: front.green, blue: front.blue, level: front.level};
         for (int i = 1; i < 4; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // Merge: with brightness off the pixel passes through untouched at level zero.
   always_comb begin
      if (side_ff[3].on) begin
         push_data = '{red: lane_red_out, green: lane_green_out, blue: lane_blue_out,
                       level: side_ff[3].level, last: side_ff[3].last};
      end else begin
         push_data = '{red: side_ff[3].red, green: side_ff[3].green,
                       blue: side_ff[3].blue, level: 5'd0, last: side_ff[3].last};
      end
   end

   assign push = en && pix_ff[3];
   assign pop  = out_valid_ff && !rsp_stall;

   // Output register with one skid entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_ff <= push_data;
         end else begin
            out_ff <= push_data;
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_red    = out_ff.red;
   assign rsp_out_green  = out_ff.green;
   assign rsp_out_blue   = out_ff.blue;
   assign rsp_out_level5 = out_ff.level;
   assign rsp_last_out   = out_ff.last;

`ifndef NO_ASSERTIONS
   // The skid entry is only ever used behind a full output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result while the output register is empty");

   // The skid entry fills only when the output was held by the consumer.
   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && rsp_stall))
      else $error("skid register filled without a stalled result ahead of it");

   // A new result appears only from a pixel at the last pipeline stage.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(pix_ff[3] && en))
      else $error("result appeared without a pixel leaving the pipeline");
`endif

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the LED pixel dimming and gamma pipeline.
`timescale 1ns / 100ps

module tb_top import ldg_pkg::*; ();

   // Table writes give no result, so the settle time before a register write covers the
   // pipeline depth with margin.
   localparam int SETTLE_CYCLES = 20;
   localparam int DRAIN_LIMIT   = 4000;
   localparam int CORR_DEPTH    = 32;

   typedef struct {
      logic       mode;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] led;
      logic       last;
      logic [2:0] sel;
      logic [7:0] idx;
      logic [7:0] data;
   } led_request_type;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [4:0] level5;
      logic       last;
   } pixel_result_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_mode;
   logic [7:0] req_red;
   logic [7:0] req_green;
   logic [7:0] req_blue;
   logic [7:0] req_led_brightness;
   logic       req_last_in;
   logic [2:0] req_table_select;
   logic [7:0] req_table_index;
   logic [7:0] req_table_data;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_red;
   logic [7:0] rsp_out_green;
   logic [7:0] rsp_out_blue;
   logic [4:0] rsp_out_level5;
   logic       rsp_last_out;
   logic       csr_write_enable;
   logic [7:0] csr_write_data;

   // Our own copy of the block's state: the brightness register and every lookup table.
   logic [7:0] global_model;
   logic [7:0] gamma_red_lut   [256];
   logic [7:0] gamma_green_lut [256];
   logic [7:0] gamma_blue_lut  [256];
   logic [4:0] dim_level_lut   [256];
   logic [7:0] dim_amount_lut  [256];
   logic [7:0] corr_red_lut    [CORR_DEPTH];
   logic [7:0] corr_green_lut  [CORR_DEPTH];
   logic [7:0] corr_blue_lut   [CORR_DEPTH];

   // Pixel results that have been predicted but not yet seen, oldest first.
   pixel_result_type pending_pixels [$];
   pixel_result_type want_pixel;

   int error_count;
   int send_idle_pct;
   int recv_stall_pct;

   led_pixel_dim_gamma_pipeline dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_red            (req_red),
      .req_green          (req_green),
      .req_blue           (req_blue),
      .req_led_brightness (req_led_brightness),
      .req_last_in        (req_last_in),
      .req_table_select   (req_table_select),
      .req_table_index    (req_table_index),
      .req_table_data     (req_table_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_red        (rsp_out_red),
      .rsp_out_green      (rsp_out_green),
      .rsp_out_blue       (rsp_out_blue),
      .rsp_out_level5     (rsp_out_level5),
      .rsp_last_out       (rsp_last_out),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Plain 8-bit scaling: x * (s + 1) / 256.
   function automatic logic [7:0] scale8(input logic [7:0] x, input logic [7:0] s);
      logic [15:0] product;
      product = {8'd0, x} * ({8'd0, s} + 16'd1);
      return product[15:8];
   endfunction

   // Video scaling never turns a nonzero value into zero unless the scale itself is zero.
   function automatic logic [7:0] scale8_video(input logic [7:0] x, input logic [7:0] s);
      logic [15:0] product;
      product = {8'd0, x} * {8'd0, s};
      return product[15:8] + ((x != 8'd0 && s != 8'd0) ? 8'd1 : 8'd0);
   endfunction

   function automatic pixel_result_type predict_pixel(input led_request_type r);
      pixel_result_type res;
      logic [15:0]   product;
      logic [7:0]    lvl;
      logic [7:0]    dim;
      logic [4:0]    level;
      logic [7:0]    corr_r;
      logic [7:0]    corr_g;
      logic [7:0]    corr_b;
      // With either brightness at zero the colour passes through untouched.
      res.red    = r.red;
      res.green  = r.green;
      res.blue   = r.blue;
      res.level5 = 5'd0;
      res.last   = r.last;
      if (global_model != 8'd0 && r.led != 8'd0) begin
         product = {8'd0, global_model} * {8'd0, r.led};
         lvl     = 8'(product / {8'd0, FULL_SCALE});
         if (lvl == 8'd0) begin
            lvl = 8'd1;
         end
         level      = dim_level_lut[lvl];
         dim        = dim_amount_lut[lvl];
         corr_r     = scale8_video(corr_red_lut[level], dim);
         corr_g     = scale8_video(corr_green_lut[level], dim);
         corr_b     = scale8_video(corr_blue_lut[level], dim);
         res.red    = gamma_red_lut[scale8(r.red, corr_r)];
         res.green  = gamma_green_lut[scale8(r.green, corr_g)];
         res.blue   = gamma_blue_lut[scale8(r.blue, corr_b)];
         res.level5 = level;
      end
      return res;
   endfunction

   function automatic void record_table_write(input led_request_type r);
      case (r.sel)
         SEL_GAMMA_RED:   gamma_red_lut[r.idx]   = r.data;
         SEL_GAMMA_GREEN: gamma_green_lut[r.idx] = r.data;
         SEL_GAMMA_BLUE:  gamma_blue_lut[r.idx]  = r.data;
         // The level table holds five bits and clips larger values.
         SEL_DIM_LEVEL:   dim_level_lut[r.idx]   =
                             (r.data > {3'd0, LEVEL_MAX}) ? LEVEL_MAX : r.data[4:0];
         SEL_DIM_AMOUNT:  dim_amount_lut[r.idx]  = r.data;
         // Correction writes past the last entry are dropped.
         SEL_CORR_RED: begin
            if (r.idx[7:5] == 3'd0) corr_red_lut[r.idx[4:0]] = r.data;
         end
         SEL_CORR_GREEN: begin
            if (r.idx[7:5] == 3'd0) corr_green_lut[r.idx[4:0]] = r.data;
         end
         default: begin
            if (r.idx[7:5] == 3'd0) corr_blue_lut[r.idx[4:0]] = r.data;
         end
      endcase
   endfunction

   function automatic led_request_type make_pixel(input logic [7:0] red,
                                                  input logic [7:0] green,
                                                  input logic [7:0] blue,
                                                  input logic [7:0] led,
                                                  input logic last);
      led_request_type r;
      r.mode  = MODE_PIXEL;
      r.red   = red;
      r.green = green;
      r.blue  = blue;
      r.led   = led;
      r.last  = last;
      // Table fields are don't-care on a pixel, so they carry noise.
      r.sel   = 3'($urandom);
      r.idx   = 8'($urandom);
      r.data  = 8'($urandom);
      return r;
   endfunction

   function automatic led_request_type make_write(input logic [2:0] sel,
                                                  input logic [7:0] idx,
                                                  input logic [7:0] data);
      led_request_type r;
      r.mode  = MODE_WRITE;
      r.red   = 8'($urandom);
      r.green = 8'($urandom);
      r.blue  = 8'($urandom);
      r.led   = 8'($urandom);
      r.last  = 1'($urandom);
      r.sel   = sel;
      r.idx   = idx;
      r.data  = data;
      return r;
   endfunction

   // Colour values lean toward the ends of the range now and then.
   function automatic logic [7:0] random_channel();
      int roll;
      roll = $urandom_range(99);
      if (roll < 15) return 8'h00;
      if (roll < 30) return 8'hFF;
      return 8'($urandom);
   endfunction

   function automatic void compare_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Presents one request and holds it until the block takes it. The random gap before it
   // drops valid; without a gap valid simply stays high into the next request.
   task automatic send_request(input led_request_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid          <= 1'b1;
      req_mode           <= r.mode;
      req_red            <= r.red;
      req_green          <= r.green;
      req_blue           <= r.blue;
      req_led_brightness <= r.led;
      req_last_in        <= r.last;
      req_table_select   <= r.sel;
      req_table_index    <= r.idx;
      req_table_data     <= r.data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // Accepted at this edge: the prediction follows request order exactly.
      if (r.mode == MODE_WRITE) begin
         record_table_write(r);
      end else begin
         pending_pixels.push_back(predict_pixel(r));
      end
   endtask

   // The brightness register is only touched while the pipeline is empty. A trailing table
   // write leaves nothing to wait for, so a settle time follows the last result.
   task automatic set_global(input logic [7:0] value);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      csr_write_data   <= 8'($urandom);
      global_model = value;
   endtask

   // Every table entry gets a value before any pixel reads it.
   task automatic test_table_fill();
      send_idle_pct  = 25;
      recv_stall_pct = 25;
      for (int i = 0; i < 256; i++) begin
         send_request(make_write(SEL_GAMMA_RED, 8'(i), 8'($urandom)));
         send_request(make_write(SEL_GAMMA_GREEN, 8'(i), 8'($urandom)));
         send_request(make_write(SEL_GAMMA_BLUE, 8'(i), 8'($urandom)));
         send_request(make_write(SEL_DIM_LEVEL, 8'(i), 8'($urandom)));
         send_request(make_write(SEL_DIM_AMOUNT, 8'(i), 8'($urandom)));
      end
      for (int i = 0; i < CORR_DEPTH; i++) begin
         send_request(make_write(SEL_CORR_RED, 8'(i), 8'($urandom)));
         send_request(make_write(SEL_CORR_GREEN, 8'(i), 8'($urandom)));
         send_request(make_write(SEL_CORR_BLUE, 8'(i), 8'($urandom)));
      end
   endtask

   // Brightness off: first with the register at its reset value and the LED dark, then with
   // the register at zero and the LED at full and half scale.
   task automatic test_brightness_off();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_request(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0));
      send_request(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
      send_request(make_pixel(8'h5A, 8'hA5, 8'h0F, 8'h00, 1'b0));
      set_global(8'h00);
      send_request(make_pixel(8'hFF, 8'h00, 8'h80, 8'hFF, 1'b1));
      send_request(make_pixel(8'h01, 8'hFE, 8'h7F, 8'h80, 1'b0));
   endtask

   // Full brightness with full correction and full dim amount takes a full-scale colour to the top gamma entry.
   task automatic test_full_scale();
      set_global(8'hFF);
      send_request(make_write(SEL_DIM_LEVEL, 8'hFF, 8'd9));
      send_request(make_write(SEL_DIM_AMOUNT, 8'hFF, 8'hFF));
      send_request(make_write(SEL_CORR_RED, 8'd9, 8'hFF));
      send_request(make_write(SEL_CORR_GREEN, 8'd9, 8'hFF));
      send_request(make_write(SEL_CORR_BLUE, 8'd9, 8'hFF));
      send_request(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
      send_request(make_pixel(8'h00, 8'h80, 8'hFF, 8'hFF, 1'b0));
   endtask

   // The lowest nonzero product rounds down to zero and must be raised to one; a zero dim
   // amount then wipes the correction out.
   task automatic test_min_level();
      set_global(8'h01);
      send_request(make_write(SEL_DIM_LEVEL, 8'h01, 8'd3));
      send_request(make_write(SEL_DIM_AMOUNT, 8'h01, 8'h00));
      send_request(make_write(SEL_CORR_RED, 8'd3, 8'd200));
      send_request(make_pixel(8'hFF, 8'h80, 8'h01, 8'h01, 1'b0));
      send_request(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFE, 1'b1));
      send_request(make_pixel(8'h40, 8'hC0, 8'hFF, 8'hFF, 1'b0));
   endtask

   // Level writes above the five-bit range clip to the top level.
   task automatic test_dim_saturation();
      set_global(8'hFF);
      send_request(make_write(SEL_DIM_LEVEL, 8'd77, 8'd200));
      send_request(make_pixel(8'hC8, 8'h64, 8'h32, 8'd77, 1'b0));
      send_request(make_write(SEL_DIM_LEVEL, 8'd77, 8'd32));
      send_request(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'd77, 1'b0));
      send_request(make_write(SEL_DIM_LEVEL, 8'd77, 8'd31));
      send_request(make_pixel(8'h80, 8'h80, 8'h80, 8'd77, 1'b1));
   endtask

   // Correction writes beyond entry 31 must leave the tables alone.
   task automatic test_corr_out_of_range();
      send_request(make_write(SEL_CORR_RED, 8'd40, 8'($urandom)));
      send_request(make_write(SEL_CORR_GREEN, 8'd255, 8'($urandom)));
      send_request(make_write(SEL_CORR_BLUE, 8'd32, 8'($urandom)));
      send_request(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
   endtask

   // Mostly pixels with random content, mixed with table rewrites that keep every entry
   // defined. Some correction writes point past the end on purpose.
   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input logic [7:0] brightness, input int count);
      led_request_type r;
      logic [2:0]   sel;
      logic [7:0]   idx;
      logic [7:0]   led;
      set_global(brightness);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      repeat (count) begin
         if ($urandom_range(99) < 20) begin
            sel = 3'($urandom);
            if (sel >= SEL_CORR_RED && $urandom_range(3) != 0) begin
               idx = 8'($urandom_range(CORR_DEPTH - 1));
            end else begin
               idx = 8'($urandom);
            end
            r = make_write(sel, idx, 8'($urandom));
         end else begin
            led = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(255, 1));
            r = make_pixel(random_channel(), random_channel(), random_channel(), led,
                           1'($urandom));
         end
         send_request(r);
      end
   endtask

   // Result side: random stalls, and every accepted result is checked against the oldest
   // prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0h %0h %0h %0h %0h",
                        $time, rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_level5,
                        rsp_last_out);
               error_count++;
            end else begin
               want_pixel = pending_pixels.pop_front();
               compare_field("out_red", want_pixel.red, rsp_out_red);
               compare_field("out_green", want_pixel.green, rsp_out_green);
               compare_field("out_blue", want_pixel.blue, rsp_out_blue);
               compare_field("out_level5", 8'(want_pixel.level5), 8'(rsp_out_level5));
               compare_field("last_out", 8'(want_pixel.last), 8'(rsp_last_out));
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Hard limit on the whole run, far beyond the slowest legal run.
   initial begin
      #(5_000_000);
      $display("led_pixel_dim_gamma_pipeline test failed");
      $finish;
   end

   initial begin
      pixel_result_type missing;
      error_count    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      global_model   = RESET_GLOBAL;

      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_mode           <= MODE_PIXEL;
      req_red            <= 8'h00;
      req_green          <= 8'h00;
      req_blue           <= 8'h00;
      req_led_brightness <= 8'h00;
      req_last_in        <= 1'b0;
      req_table_select   <= SEL_GAMMA_RED;
      req_table_index    <= 8'h00;
      req_table_data     <= 8'h00;
      csr_write_enable   <= 1'b0;
      csr_write_data     <= 8'h00;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_table_fill();
      test_brightness_off();
      test_full_scale();
      test_min_level();
      test_dim_saturation();
      test_corr_out_of_range();

      // Idling phases: none, sender only, receiver only, both, with several brightness
      // settings including both extremes.
      test_random_traffic(0, 0, 8'hFF, 60);
      test_random_traffic(55, 0, 8'($urandom), 40);
      test_random_traffic(0, 55, 8'h01, 40);
      test_random_traffic(25, 25, 8'($urandom), 40);
      test_random_traffic(55, 0, 8'h00, 20);
      test_random_traffic(0, 55, 8'($urandom), 30);
      test_random_traffic(25, 25, 8'h80, 20);

      // Drain: wait for every prediction to be met, then let the pipeline run dry.
      req_valid <= 1'b0;
      for (int n = 0; n < DRAIN_LIMIT && pending_pixels.size() != 0; n++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (pending_pixels.size() != 0) begin
         missing = pending_pixels.pop_front();
         $display("%0t: missing result, expected %0h %0h %0h %0h %0h, actual none", $time,
                  missing.red, missing.green, missing.blue, missing.level5,
                  missing.last);
         error_count++;
      end

      if (error_count == 0) begin
         $display("led_pixel_dim_gamma_pipeline test passed");
      end else begin
         $display("led_pixel_dim_gamma_pipeline test failed");
      end
      $finish;
   end

endmodule

[led_pixel_dim_gamma_pipeline.f]
sv/ldg_pkg.sv
sv/ldg_front.sv
sv/ldg_lane.sv
sv/led_pixel_dim_gamma_pipeline.sv
bench/tb_top.sv
